[hw/rtl/dpwl_pkg.sv]
// dpwl_pkg: shared constants, types and helper functions of the dual pool
// wear leveling core. No dependencies; used by every other file of the block.

package dpwl_pkg;

  // sizing
  localparam int NUM_BLOCKS  = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int SCAN_W      = $clog2(NUM_BLOCKS + 1);

  // word field widths
  localparam int KIND_W      = 2;
  localparam int BLK_W       = 10;
  localparam int CNT_FIELD_W = 16;
  localparam int THR_W       = 16;
  localparam int BIU_W       = 11;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);
  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(1024);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 8'd1;

  // entry update operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_ERASE    = 3'd0;
  localparam logic [OP_W-1:0] OP_ASSIGN   = 3'd1;
  localparam logic [OP_W-1:0] OP_MIG_HOT  = 3'd2;
  localparam logic [OP_W-1:0] OP_MIG_COLD = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_HOT  = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_COLD = 3'd5;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // one block entry of the state memory
  typedef struct packed {
    cnt_t erase;
    cnt_t recent;
    logic pool;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{erase: '0, recent: '0, pool: 1'b1};

  // running extremes of one pool
  typedef struct packed {
    logic any;
    cnt_t max_v;
    cnt_t min_v;
    cnt_t max_rv;
    cnt_t min_rv;
    idx_t max_b;
    idx_t min_b;
    idx_t max_rb;
  } pool_scan_t;

  // scan results handed from the scan unit to the sequencer
  typedef struct packed {
    pool_scan_t hot;
    pool_scan_t cold;
    cnt_t       gmax;
    cnt_t       gmin;
  } scan_res_t;

  // one result word
  typedef struct packed {
    logic             migrate;
    logic [BLK_W-1:0] migrate_hot_block;
    logic [BLK_W-1:0] migrate_cold_block;
    logic             cold_adjust;
    logic [BLK_W-1:0] cold_adjust_block;
    logic             hot_adjust;
    logic [BLK_W-1:0] hot_adjust_block;
    logic [CNT_FIELD_W-1:0] max_erase;
    logic [CNT_FIELD_W-1:0] min_erase;
  } res_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // read-modify-write of one entry
  function automatic entry_t apply_op(entry_t e, logic [OP_W-1:0] op, logic pool);
    entry_t r;
    r = e;
    unique case (op)
      OP_ERASE: begin
        r.erase  = sat_inc(e.erase);
        r.recent = sat_inc(e.recent);
      end
      OP_ASSIGN:   r.pool = pool;
      OP_MIG_HOT: begin
        r.erase  = sat_inc(e.erase);
        r.recent = '0;
        r.pool   = 1'b0;
      end
      OP_MIG_COLD: begin
        r.erase  = sat_inc(e.erase);
        r.recent = sat_inc(e.recent);
        r.pool   = 1'b1;
      end
      OP_SET_HOT:  r.pool = 1'b1;
      OP_SET_COLD: r.pool = 1'b0;
      default:     r = e;
    endcase
    return r;
  endfunction

  // fold one block into a pool's extremes
  function automatic pool_scan_t scan_add(pool_scan_t s, idx_t b, cnt_t e, cnt_t r);
    pool_scan_t n;
    n = s;
    if (!s.any) begin
      n.any    = 1'b1;
      n.max_v  = e;
      n.min_v  = e;
      n.max_rv = r;
      n.min_rv = r;
      n.max_b  = b;
      n.min_b  = b;
      n.max_rb = b;
    end else begin
      if (e > s.max_v) begin
        n.max_v = e;
        n.max_b = b;
      end
      if (e <= s.min_v) begin
        n.min_v = e;
        n.min_b = b;
      end
      if (r > s.max_rv) begin
        n.max_rv = r;
        n.max_rb = b;
      end
      if (r <= s.min_rv) n.min_rv = r;
    end
    return n;
  endfunction

  // index to block field, zero extended or truncated
  function automatic logic [BLK_W-1:0] to_blk_field(idx_t b);
    logic [IDX_W+BLK_W-1:0] w;
    w = {{BLK_W{1'b0}}, b};
    return w[BLK_W-1:0];
  endfunction

  // block field to memory index
  function automatic idx_t blk_to_idx(logic [BLK_W-1:0] b);
    logic [IDX_W+BLK_W-1:0] w;
    w = {{IDX_W{1'b0}}, b};
    return w[IDX_W-1:0];
  endfunction

  // count to result count field
  function automatic logic [CNT_FIELD_W-1:0] to_count_field(cnt_t c);
    logic [COUNT_WIDTH+CNT_FIELD_W-1:0] w;
    w = {{CNT_FIELD_W{1'b0}}, c};
    return w[CNT_FIELD_W-1:0];
  endfunction

endpackage

[hw/rtl/dpwl_if.sv]
// dpwl_if: valid/ready channel interfaces of the wear leveling core
// (item input, result output, configuration write). Depends on dpwl_pkg.

// item input channel
interface dpwl_in_if;
  logic                         valid;
  logic                         ready;
  logic [dpwl_pkg::KIND_W-1:0]  kind;
  logic [dpwl_pkg::BLK_W-1:0]   block;
  logic                         pool;

  modport source (output valid, kind, block, pool, input ready);
  modport sink   (input valid, kind, block, pool, output ready);
endinterface

// result channel
interface dpwl_out_if;
  logic                              valid;
  logic                              ready;
  logic                              migrate;
  logic [dpwl_pkg::BLK_W-1:0]        migrate_hot_block;
  logic [dpwl_pkg::BLK_W-1:0]        migrate_cold_block;
  logic                              cold_adjust;
  logic [dpwl_pkg::BLK_W-1:0]        cold_adjust_block;
  logic                              hot_adjust;
  logic [dpwl_pkg::BLK_W-1:0]        hot_adjust_block;
  logic [dpwl_pkg::CNT_FIELD_W-1:0]  max_erase;
  logic [dpwl_pkg::CNT_FIELD_W-1:0]  min_erase;

  modport source (output valid, migrate, migrate_hot_block, migrate_cold_block,
                  cold_adjust, cold_adjust_block, hot_adjust, hot_adjust_block,
                  max_erase, min_erase, input ready);
  modport sink   (input valid, migrate, migrate_hot_block, migrate_cold_block,
                  cold_adjust, cold_adjust_block, hot_adjust, hot_adjust_block,
                  max_erase, min_erase, output ready);
endinterface

// configuration write channel
interface dpwl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dpwl_pkg::CFG_IDX_W-1:0]    index;
  logic [dpwl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dual_pool_wear_leveling_core.sv]
// Dual pool wear leveling core: one result word per item word. Per-block state
// sits in a single-port-read, single-port-write memory of NUM_BLOCKS entries,
// so every entry update is a read followed by a write-back. After reset the
// core runs a clearing pass over all NUM_BLOCKS entries (1024) before it takes
// its first item; configuration writes are taken at any time. Erase and pool
// assign items pass through a read state and a write-back state to the output
// state; kind 3 items and out-of-range blocks go straight to the output state
// (no entry is touched). An evaluate item sweeps the memory one entry per
// cycle, then decides, then runs each entry update (up to 4 updates) as a read
// and a write-back, and then posts the result. The next item is accepted once
// the previous result is in the output register.
// Depends on dpwl_pkg, dpwl_if, dpwl_block_mem and dpwl_scan.

module dual_pool_wear_leveling_core (
  input  logic              clk,
  input  logic              rst_n,
  dpwl_in_if.sink           in_ch,
  dpwl_out_if.source        out_ch,
  dpwl_cfg_if.sink          cfg_ch
);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_WR     = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  localparam int DIFF_W = ((dpwl_pkg::COUNT_WIDTH > dpwl_pkg::THR_W + 1) ?
                           dpwl_pkg::COUNT_WIDTH : dpwl_pkg::THR_W + 1) + 2;

  logic [2:0]                        state_r, state_nxt;
  dpwl_pkg::idx_t                    clr_idx_r, clr_idx_nxt;
  logic [dpwl_pkg::THR_W-1:0]        threshold_r, threshold_nxt;
  logic [dpwl_pkg::BIU_W-1:0]        biu_r, biu_nxt;
  logic [dpwl_pkg::OP_W-1:0]         op_r, op_nxt;
  dpwl_pkg::idx_t                    addr_r, addr_nxt;
  logic                              pool_r, pool_nxt;
  logic [3:0]                        pend_r, pend_nxt;
  logic [dpwl_pkg::SCAN_W-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic [dpwl_pkg::SCAN_W-1:0]       n_r, n_nxt;
  logic                              scan_vld_r, scan_vld_nxt;
  dpwl_pkg::idx_t                    scan_idx_r, scan_idx_nxt;
  dpwl_pkg::res_t                    res_r, res_nxt;
  dpwl_pkg::res_t                    out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic                              in_fire;
  logic                              in_range;
  logic [31:0]                       biu32;
  logic [31:0]                       n32;
  logic                              scan_clear;

  logic                              rd_en;
  dpwl_pkg::idx_t                    rd_addr;
  dpwl_pkg::entry_t                  rd_data;
  logic                              wr_en;
  dpwl_pkg::idx_t                    wr_addr;
  dpwl_pkg::entry_t                  wr_data;
  dpwl_pkg::scan_res_t               scan;

  logic signed [DIFF_W-1:0]          thr_s, thr2_s, d_mig, d_cadj, d_hadj;
  logic                              do_mig, do_cadj, do_hadj, scanned;
  logic [3:0]                        dec_mask;
  logic [3:0]                        pick_src, pick_left;
  logic [dpwl_pkg::OP_W-1:0]         pick_op;
  dpwl_pkg::idx_t                    pick_addr;

  // state memory and scan unit
  dpwl_block_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  dpwl_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (scan_clear),
    .in_vld   (scan_vld_r),
    .in_idx   (scan_idx_r),
    .in_entry (rd_data),
    .res      (scan)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_range     = 32'(in_ch.block) < 32'(dpwl_pkg::NUM_BLOCKS);

  // scan length clipped to the memory depth
  assign biu32 = 32'(biu_r);
  assign n32   = (biu32 > 32'(dpwl_pkg::NUM_BLOCKS)) ? 32'(dpwl_pkg::NUM_BLOCKS) : biu32;

  // rule checks on the scan results
  always_comb begin
    thr_s   = $signed(DIFF_W'(threshold_r));
    thr2_s  = $signed(DIFF_W'({threshold_r, 1'b0}));
    d_mig   = $signed(DIFF_W'(scan.hot.max_v)) - $signed(DIFF_W'(scan.cold.min_v));
    d_cadj  = $signed(DIFF_W'(scan.cold.max_rv)) - $signed(DIFF_W'(scan.hot.min_rv));
    d_hadj  = $signed(DIFF_W'(scan.hot.max_v)) - $signed(DIFF_W'(scan.hot.min_v));
    do_mig  = scan.hot.any && scan.cold.any && (d_mig > thr_s);
    do_cadj = scan.hot.any && scan.cold.any && (d_cadj > thr_s);
    do_hadj = scan.hot.any && (d_hadj > thr2_s);
    scanned = scan.hot.any || scan.cold.any;
    dec_mask = {do_hadj, do_cadj, do_mig, do_mig};
  end

  // next pending entry update, in rule order
  always_comb begin
    pick_src  = (state_r == ST_DECIDE) ? dec_mask : pend_r;
    pick_left = pick_src;
    pick_op   = dpwl_pkg::OP_SET_COLD;
    pick_addr = scan.hot.min_b;
    if (pick_src[0]) begin
      pick_op      = dpwl_pkg::OP_MIG_HOT;
      pick_addr    = scan.hot.max_b;
      pick_left[0] = 1'b0;
    end else if (pick_src[1]) begin
      pick_op      = dpwl_pkg::OP_MIG_COLD;
      pick_addr    = scan.cold.min_b;
      pick_left[1] = 1'b0;
    end else if (pick_src[2]) begin
      pick_op      = dpwl_pkg::OP_SET_HOT;
      pick_addr    = scan.cold.max_rb;
      pick_left[2] = 1'b0;
    end else begin
      pick_left[3] = 1'b0;
    end
  end

  // configuration writes
  always_comb begin
    threshold_nxt = threshold_r;
    biu_nxt       = biu_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        dpwl_pkg::REG_THRESHOLD:     threshold_nxt = cfg_ch.data[dpwl_pkg::THR_W-1:0];
        dpwl_pkg::REG_BLOCKS_IN_USE: biu_nxt = cfg_ch.data[dpwl_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    pool_nxt      = pool_r;
    pend_nxt      = pend_r;
    scan_cnt_nxt  = scan_cnt_r;
    n_nxt         = n_r;
    scan_vld_nxt  = 1'b0;
    scan_idx_nxt  = scan_idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    scan_clear    = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = dpwl_pkg::apply_op(rd_data, op_r, pool_r);

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = dpwl_pkg::ENTRY_RESET;
        clr_idx_nxt = clr_idx_r + dpwl_pkg::idx_t'(1);
        if (clr_idx_r == dpwl_pkg::idx_t'(dpwl_pkg::NUM_BLOCKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt  = '0;
          pend_nxt = '0;
          addr_nxt = dpwl_pkg::blk_to_idx(in_ch.block);
          pool_nxt = in_ch.pool;
          unique case (in_ch.kind)
            dpwl_pkg::KIND_ERASE: begin
              op_nxt    = dpwl_pkg::OP_ERASE;
              state_nxt = in_range ? ST_RD : ST_OUT;
            end
            dpwl_pkg::KIND_ASSIGN: begin
              op_nxt    = dpwl_pkg::OP_ASSIGN;
              state_nxt = in_range ? ST_RD : ST_OUT;
            end
            dpwl_pkg::KIND_EVAL: begin
              scan_clear   = 1'b1;
              scan_cnt_nxt = '0;
              n_nxt        = n32[dpwl_pkg::SCAN_W-1:0];
              state_nxt    = ST_SCAN;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        wr_en = 1'b1;
        if (|pend_r) begin
          op_nxt    = pick_op;
          addr_nxt  = pick_addr;
          pend_nxt  = pick_left;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN: begin
        // one read per cycle, the scan unit folds each word from the registered read data
        rd_addr = scan_cnt_r[dpwl_pkg::IDX_W-1:0];
        if (scan_cnt_r != n_r) begin
          rd_en        = 1'b1;
          scan_vld_nxt = 1'b1;
          scan_idx_nxt = scan_cnt_r[dpwl_pkg::IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + dpwl_pkg::SCAN_W'(1);
        end else if (!scan_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_nxt.migrate            = do_mig;
        res_nxt.migrate_hot_block  = do_mig ? dpwl_pkg::to_blk_field(scan.hot.max_b) : '0;
        res_nxt.migrate_cold_block = do_mig ? dpwl_pkg::to_blk_field(scan.cold.min_b) : '0;
        res_nxt.cold_adjust        = do_cadj;
        res_nxt.cold_adjust_block  = do_cadj ? dpwl_pkg::to_blk_field(scan.cold.max_rb) : '0;
        res_nxt.hot_adjust         = do_hadj;
        res_nxt.hot_adjust_block   = do_hadj ? dpwl_pkg::to_blk_field(scan.hot.min_b) : '0;
        res_nxt.max_erase          = scanned ? dpwl_pkg::to_count_field(scan.gmax) : '0;
        res_nxt.min_erase          = scanned ? dpwl_pkg::to_count_field(scan.gmin) : '0;
        if (|dec_mask) begin
          op_nxt    = pick_op;
          addr_nxt  = pick_addr;
          pend_nxt  = pick_left;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      threshold_r <= dpwl_pkg::THR_RESET;
      biu_r       <= dpwl_pkg::BIU_RESET;
      pend_r      <= '0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      threshold_r <= threshold_nxt;
      biu_r       <= biu_nxt;
      pend_r      <= pend_nxt;
      scan_vld_r  <= scan_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    pool_r     <= pool_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    n_r        <= n_nxt;
    scan_idx_r <= scan_idx_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // result channel
  assign out_ch.valid              = out_valid_r;
  assign out_ch.migrate            = out_r.migrate;
  assign out_ch.migrate_hot_block  = out_r.migrate_hot_block;
  assign out_ch.migrate_cold_block = out_r.migrate_cold_block;
  assign out_ch.cold_adjust        = out_r.cold_adjust;
  assign out_ch.cold_adjust_block  = out_r.cold_adjust_block;
  assign out_ch.hot_adjust         = out_r.hot_adjust;
  assign out_ch.hot_adjust_block   = out_r.hot_adjust_block;
  assign out_ch.max_erase          = out_r.max_erase;
  assign out_ch.min_erase          = out_r.min_erase;

endmodule

[hw/rtl/dpwl_block_mem.sv]
// dpwl_block_mem: per-block state memory (erase count, recent count, pool bit),
// one write and one read port, registered read data. Depends on dpwl_pkg.

module dpwl_block_mem (
  input  logic               clk,
  input  logic               rd_en,
  input  dpwl_pkg::idx_t     rd_addr,
  output dpwl_pkg::entry_t   rd_data,
  input  logic               wr_en,
  input  dpwl_pkg::idx_t     wr_addr,
  input  dpwl_pkg::entry_t   wr_data
);

  dpwl_pkg::entry_t mem [dpwl_pkg::NUM_BLOCKS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/dpwl_scan.sv]
// dpwl_scan: accumulates per-pool and global extremes over the entries read
// during an evaluation sweep. Depends on dpwl_pkg.

module dpwl_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 in_vld,
  input  dpwl_pkg::idx_t       in_idx,
  input  dpwl_pkg::entry_t     in_entry,
  output dpwl_pkg::scan_res_t  res
);

  dpwl_pkg::pool_scan_t hot_r, hot_nxt;
  dpwl_pkg::pool_scan_t cold_r, cold_nxt;
  dpwl_pkg::cnt_t       gmax_r, gmax_nxt;
  dpwl_pkg::cnt_t       gmin_r, gmin_nxt;
  logic                 first;

  assign first = !(hot_r.any || cold_r.any);

  // fold the incoming entry into its pool and the global extremes
  always_comb begin
    hot_nxt  = hot_r;
    cold_nxt = cold_r;
    gmax_nxt = gmax_r;
    gmin_nxt = gmin_r;
    if (clear) begin
      hot_nxt.any  = 1'b0;
      cold_nxt.any = 1'b0;
    end else if (in_vld) begin
      if (in_entry.pool) begin
        hot_nxt = dpwl_pkg::scan_add(hot_r, in_idx, in_entry.erase, in_entry.recent);
      end else begin
        cold_nxt = dpwl_pkg::scan_add(cold_r, in_idx, in_entry.erase, in_entry.recent);
      end
      if (first || in_entry.erase > gmax_r) gmax_nxt = in_entry.erase;
      if (first || in_entry.erase < gmin_r) gmin_nxt = in_entry.erase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_r  <= '0;
      cold_r <= '0;
    end else begin
      hot_r  <= hot_nxt;
      cold_r <= cold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gmax_r <= gmax_nxt;
    gmin_r <= gmin_nxt;
  end

  assign res = '{hot: hot_r, cold: cold_r, gmax: gmax_r, gmin: gmin_r};

endmodule

[tb/tb_dual_pool_wear_leveling_core.sv]
// tb_dual_pool_wear_leveling_core: self-checking bench for the dual pool wear
// leveling core, with an in-bench predictor of per-block wear state and a
// scoreboard of result words. Depends on dpwl_pkg, dpwl_if and the core RTL.

module tb_dual_pool_wear_leveling_core;
  import dpwl_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 8'hFF;
  localparam int COLD = 0;
  localparam int HOT  = 1;
  localparam int NUM_PHASES       = 8;
  localparam int RANDOM_PER_PHASE = 68;
  localparam int FILL_ERASES      = 8;
  localparam int LONG_HOLD        = 500;
  localparam int MAX_GAP          = 13;
  localparam longint CYCLE_LIMIT  = 6000000;

  // one input word plus a flag to hold it back until the core has drained
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  block;
    logic              pool;
    bit                drain_first;
  } word_t;

  // running extremes of one pool during an evaluation sweep
  typedef struct packed {
    logic any;
    cnt_t max_v;
    cnt_t min_v;
    cnt_t max_rv;
    cnt_t min_rv;
    idx_t max_b;
    idx_t min_b;
    idx_t max_rb;
  } pool_extremes_t;

  logic clk = 1'b0;
  logic rst_n;

  dpwl_in_if  in_bus ();
  dpwl_out_if out_bus ();
  dpwl_cfg_if cfg_bus ();

  dual_pool_wear_leveling_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #1 clk = ~clk;

  // predicted wear state and register copies
  cnt_t             wear [NUM_BLOCKS];
  cnt_t             recent_wear [NUM_BLOCKS];
  logic             is_hot [NUM_BLOCKS];
  logic [THR_W-1:0] level_thr;
  logic [BIU_W-1:0] scan_len;

  word_t word_backlog [$];
  res_t  predicted_reports [$];
  word_t cur_word;

  int  words_taken;
  int  results_done;
  int  results_checked;
  int  bad_cnt;
  int  send_gap;
  int  recv_gap;
  int  long_hold_left;
  int  cfg_writes;
  int  eval_cnt, migrate_cnt, cold_move_cnt, hot_move_cnt;
  bit  no_gaps;
  longint cycle_cnt;

  function automatic cnt_t count_up(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // apply one word to the predicted state and return its result word
  function automatic res_t level_word(word_t w);
    res_t r;
    pool_extremes_t ext [2];
    int n, i, p, thr;
    cnt_t e, rc;
    idx_t hb, cb;
    logic both;
    r = '0;
    case (w.kind)
      KIND_ERASE: begin
        wear[w.block] = count_up(wear[w.block]);
        recent_wear[w.block] = count_up(recent_wear[w.block]);
      end
      KIND_ASSIGN: is_hot[w.block] = w.pool;
      KIND_EVAL: begin
        n = int'(scan_len);
        if (n > NUM_BLOCKS) n = NUM_BLOCKS;
        ext[COLD] = '0;
        ext[HOT] = '0;
        // one sweep: global extremes and per-pool extremes
        for (i = 0; i < n; i++) begin
          e = wear[i];
          rc = recent_wear[i];
          p = is_hot[i] ? HOT : COLD;
          if (i == 0 || e > r.max_erase) r.max_erase = e;
          if (i == 0 || e < r.min_erase) r.min_erase = e;
          if (!ext[p].any) begin
            ext[p].any = 1'b1;
            ext[p].max_v = e;
            ext[p].min_v = e;
            ext[p].max_rv = rc;
            ext[p].min_rv = rc;
            ext[p].max_b = idx_t'(i);
            ext[p].min_b = idx_t'(i);
            ext[p].max_rb = idx_t'(i);
          end else begin
            // max keeps the first strict winner, min the last tie
            if (e > ext[p].max_v) begin
              ext[p].max_v = e;
              ext[p].max_b = idx_t'(i);
            end
            if (e <= ext[p].min_v) begin
              ext[p].min_v = e;
              ext[p].min_b = idx_t'(i);
            end
            if (rc > ext[p].max_rv) begin
              ext[p].max_rv = rc;
              ext[p].max_rb = idx_t'(i);
            end
            if (rc <= ext[p].min_rv) ext[p].min_rv = rc;
          end
        end
        thr = int'(level_thr);
        both = ext[HOT].any && ext[COLD].any;
        // cold data migration
        if (both && int'(ext[HOT].max_v) - int'(ext[COLD].min_v) > thr) begin
          hb = ext[HOT].max_b;
          cb = ext[COLD].min_b;
          wear[hb] = count_up(wear[hb]);
          wear[cb] = count_up(wear[cb]);
          recent_wear[cb] = count_up(recent_wear[cb]);
          recent_wear[hb] = '0;
          is_hot[hb] = 1'b0;
          is_hot[cb] = 1'b1;
          r.migrate = 1'b1;
          r.migrate_hot_block = hb;
          r.migrate_cold_block = cb;
        end
        // cold-pool adjustment on recent counts
        if (both && int'(ext[COLD].max_rv) - int'(ext[HOT].min_rv) > thr) begin
          is_hot[ext[COLD].max_rb] = 1'b1;
          r.cold_adjust = 1'b1;
          r.cold_adjust_block = ext[COLD].max_rb;
        end
        // hot-pool adjustment at twice the threshold
        if (ext[HOT].any && int'(ext[HOT].max_v) - int'(ext[HOT].min_v) > 2 * thr) begin
          is_hot[ext[HOT].min_b] = 1'b0;
          r.hot_adjust = 1'b1;
          r.hot_adjust_block = ext[HOT].min_b;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_gaps || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void add_word(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] block,
                                   logic pool, bit drain_first);
    word_t w;
    w.kind = kind;
    w.block = block;
    w.pool = pool;
    w.drain_first = drain_first;
    word_backlog.push_back(w);
  endfunction

  // mostly erase/assign/evaluate on scanned blocks, erases biased to a few
  // blocks so the pools drift apart, plus some noise over the whole range
  function automatic void queue_random(int count, int span);
    word_t w;
    int k, kroll, broll;
    for (k = 0; k < count; k++) begin
      kroll = $urandom_range(0, 99);
      if (kroll < 48) w.kind = KIND_ERASE;
      else if (kroll < 66) w.kind = KIND_ASSIGN;
      else if (kroll < 92) w.kind = KIND_EVAL;
      else w.kind = KIND_W'($urandom_range(0, 3));
      broll = $urandom_range(0, 99);
      if (broll < 10) w.block = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
      else if (w.kind == KIND_ERASE && broll < 60)
        w.block = BLK_W'($urandom_range(0, (span < 4 ? span : 4) - 1));
      else w.block = BLK_W'($urandom_range(0, span - 1));
      w.pool = 1'($urandom_range(0, 1));
      w.drain_first = ($urandom_range(0, 99) < 3);
      word_backlog.push_back(w);
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("mismatch in result word %0d, %s: expected %0d, got %0d",
                 results_checked, name, want, got);
    end
  endtask

  task automatic check_report(input res_t got);
    res_t want;
    if (predicted_reports.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10) $display("result word %0d with nothing expected: %h",
                                  results_checked, got);
    end else begin
      want = predicted_reports.pop_front();
      compare_field("migrate", 32'(want.migrate), 32'(got.migrate));
      compare_field("migrate_hot_block", 32'(want.migrate_hot_block),
                    32'(got.migrate_hot_block));
      compare_field("migrate_cold_block", 32'(want.migrate_cold_block),
                    32'(got.migrate_cold_block));
      compare_field("cold_adjust", 32'(want.cold_adjust), 32'(got.cold_adjust));
      compare_field("cold_adjust_block", 32'(want.cold_adjust_block),
                    32'(got.cold_adjust_block));
      compare_field("hot_adjust", 32'(want.hot_adjust), 32'(got.hot_adjust));
      compare_field("hot_adjust_block", 32'(want.hot_adjust_block),
                    32'(got.hot_adjust_block));
      compare_field("max_erase", 32'(want.max_erase), 32'(got.max_erase));
      compare_field("min_erase", 32'(want.min_erase), 32'(got.min_erase));
    end
    results_checked++;
  endtask

  // word driver: predicts each accepted word, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predicted_reports.push_back(level_word(cur_word));
        words_taken++;
        if (cur_word.kind == KIND_EVAL) eval_cnt++;
        migrate_cnt += int'(predicted_reports[$].migrate);
        cold_move_cnt += int'(predicted_reports[$].cold_adjust);
        hot_move_cnt += int'(predicted_reports[$].hot_adjust);
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the offered word
      end else if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (word_backlog.size() != 0 &&
                   (!word_backlog[0].drain_first || results_done == words_taken)) begin
        cur_word = word_backlog.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.kind  <= cur_word.kind;
        in_bus.block <= cur_word.block;
        in_bus.pool  <= cur_word.pool;
        send_gap = draw_gap();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted down on its own
  always @(posedge clk) begin
    if (long_hold_left != 0) long_hold_left <= long_hold_left - 1;
  end

  // result monitor: checks every accepted word, stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_report({out_bus.migrate, out_bus.migrate_hot_block, out_bus.migrate_cold_block,
                      out_bus.cold_adjust, out_bus.cold_adjust_block, out_bus.hot_adjust,
                      out_bus.hot_adjust_block, out_bus.max_erase, out_bus.min_erase});
        results_done <= results_done + 1;
        recv_gap = draw_gap();
      end
      if (long_hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // register write, only issued while the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_THRESHOLD:     level_thr = val[THR_W-1:0];
      REG_BLOCKS_IN_USE: scan_len = val[BIU_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // wait until every queued word is in and every result word is back
  task automatic settle();
    do @(posedge clk);
    while (word_backlog.size() != 0 || in_bus.valid || results_done != words_taken);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] phase_thr [NUM_PHASES];
    logic [CFG_DATA_W-1:0] phase_biu [NUM_PHASES];
    int ph, span, k;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_ERASE;
    in_bus.block = '0;
    in_bus.pool = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_THRESHOLD;
    cfg_bus.data = '0;
    no_gaps = 1'b0;
    long_hold_left = 0;
    for (k = 0; k < NUM_BLOCKS; k++) begin
      wear[k] = '0;
      recent_wear[k] = '0;
      is_hot[k] = 1'b1;
    end
    level_thr = THR_RESET;
    scan_len = BIU_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // full sweep with reset registers: one pool only, all counts zero
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    settle();
    write_reg(REG_THRESHOLD, 16'd2);
    write_reg(REG_BLOCKS_IN_USE, 16'd8);
    // build a gap between pools, then evaluate after a full drain
    add_word(KIND_ERASE, 10'd0, 1'b0, 1'b0);
    add_word(KIND_ERASE, 10'd0, 1'b1, 1'b0);
    add_word(KIND_ERASE, 10'd0, 1'b0, 1'b0);
    add_word(KIND_ERASE, 10'd3, 1'b0, 1'b0);
    add_word(KIND_ASSIGN, 10'd5, 1'b0, 1'b0);
    add_word(KIND_ASSIGN, 10'd6, 1'b0, 1'b0);
    add_word(KIND_ERASE, 10'd6, 1'b0, 1'b0);
    add_word(KIND_EVAL, 10'd1023, 1'b1, 1'b1);
    // unknown kind and the top block, outside the scan
    add_word(KIND_UNUSED, 10'd1023, 1'b1, 1'b0);
    add_word(KIND_ERASE, 10'd1023, 1'b0, 1'b0);
    add_word(KIND_ASSIGN, 10'd1023, 1'b0, 1'b0);
    add_word(KIND_ASSIGN, 10'd1023, 1'b1, 1'b0);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    settle();
    // empty scan, zero threshold
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_BLOCKS_IN_USE, 16'd0);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    add_word(KIND_ERASE, 10'd2, 1'b0, 1'b0);
    settle();
    // upper data bits beyond the register width are dropped
    write_reg(REG_BLOCKS_IN_USE, 16'hF803);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    settle();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_BLOCKS_IN_USE, 16'd2047);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    settle();
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_BLOCKS_IN_USE, 16'd1);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);

    // random phases over several register settings
    phase_thr = '{16'd1, 16'd0, 16'd3, 16'd2, 16'hFFFF, 16'd2, 16'd5, 16'd0};
    phase_biu = '{16'd8, 16'd4, 16'd32, 16'd2, 16'd64, 16'd1024, 16'd16, 16'd1};
    phase_thr[NUM_PHASES-1] = CFG_DATA_W'($urandom_range(0, 65535));
    phase_biu[NUM_PHASES-1] = CFG_DATA_W'($urandom_range(1, 48));
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(REG_THRESHOLD, phase_thr[ph]);
      write_reg(REG_BLOCKS_IN_USE, phase_biu[ph]);
      span = int'(phase_biu[ph][BIU_W-1:0]);
      if (span > NUM_BLOCKS) span = NUM_BLOCKS;
      if (span < 1) span = 1;
      no_gaps = (ph == 3);
      if (ph == 1) begin
        // receiver holds off while words keep coming, so the input backs up
        @(posedge clk);
        long_hold_left <= LONG_HOLD;
      end
      queue_random(RANDOM_PER_PHASE, span);
    end

    // wear the top block well ahead of the rest, then evaluate around it
    settle();
    write_reg(REG_THRESHOLD, 16'd4);
    write_reg(REG_BLOCKS_IN_USE, 16'd1024);
    no_gaps = 1'b1;
    add_word(KIND_ASSIGN, 10'd1022, 1'b0, 1'b0);
    add_word(KIND_ASSIGN, 10'd1023, 1'b1, 1'b0);
    for (k = 0; k < FILL_ERASES; k++) add_word(KIND_ERASE, 10'd1023, 1'b0, 1'b0);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    add_word(KIND_ERASE, 10'd1023, 1'b0, 1'b0);
    add_word(KIND_ERASE, 10'd1023, 1'b0, 1'b0);
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    settle();
    write_reg(REG_THRESHOLD, 16'hFFFF);
    no_gaps = 1'b0;
    add_word(KIND_EVAL, '0, 1'b0, 1'b0);
    settle();
    repeat (64) @(posedge clk);

    if (predicted_reports.size() != 0)
      $display("%0d expected result words never arrived", predicted_reports.size());
    $display("checked %0d result words over %0d register writes: %0d evaluations,",
             results_checked, cfg_writes, eval_cnt);
    $display("%0d migrations, %0d cold moves, %0d hot moves, one block worn far ahead",
             migrate_cnt, cold_move_cnt, hot_move_cnt);
    if (bad_cnt == 0 && predicted_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
